// ===== design/bsc_pkg.sv =====
package bsc_pkg;

	localparam int RAW_W      = 24;
	localparam int FACTOR_W   = 23;
	localparam int QUOT_W     = 30;
	localparam int DIV_STEPS  = QUOT_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int OUT_W      = 32;
	localparam int CODE_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_WORD_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_WORD_HIGH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CUBIC     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_OS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_OS       = 3'd4;

	typedef logic [FACTOR_W-1:0] factor_t;

	function automatic factor_t scale_factor(input logic [2:0] code);
		factor_t f;
		case (code)
			3'd0: f = 23'd524288;
			3'd1: f = 23'd1572864;
			3'd2: f = 23'd3670016;
			3'd3: f = 23'd7864320;
			3'd4: f = 23'd253952;
			3'd5: f = 23'd516096;
			3'd6: f = 23'd1040384;
			3'd7: f = 23'd2088960;
			default: f = 23'd524288;
		endcase
		return f;
	endfunction

endpackage

// ===== design/baro_sensor_compensation.sv =====
// Compensates raw barometric sensor samples: a temperature sample gives degrees C, a pressure
// sample gives pascal, both signed with 8 fractional bits and saturated to 32 bits. One sample
// is in work at a time and sample_ready is low meanwhile. A sample first runs through the
// bit-serial divider that scales the raw sample, then through products on the shared 32x32
// multiplier (one product for temperature, six for pressure, each built from two partial
// products), then through the final sum and the rounding to the output format. A sample whose
// oversampling code is unsupported skips the divider and the multiplier and returns an error
// result. The result sits in an output register, so the next sample is accepted while it waits.
module baro_sensor_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	input  logic                                command,
	input  logic [bsc_pkg::RAW_W-1:0]           raw_sample,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                result_kind,
	output logic signed [bsc_pkg::OUT_W-1:0]    compensated,
	output logic                                error,
	input  logic                                cfg_we,
	input  logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_SUM  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [2:0] OP_CUBE  = 3'd0;
	localparam logic [2:0] OP_QUAD  = 3'd1;
	localparam logic [2:0] OP_LIN   = 3'd2;
	localparam logic [2:0] OP_C21   = 3'd3;
	localparam logic [2:0] OP_C11   = 3'd4;
	localparam logic [2:0] OP_CROSS = 3'd5;
	localparam logic [2:0] OP_TEMP  = 3'd6;

	localparam logic [2:0] PH_LOAD = 3'd0;
	localparam logic [2:0] PH_LO   = 3'd1;
	localparam logic [2:0] PH_HI   = 3'd2;
	localparam logic [2:0] PH_ACC  = 3'd3;
	localparam logic [2:0] PH_RND  = 3'd4;
	localparam logic [2:0] PH_ADD  = 3'd5;

	localparam int FW = bsc_pkg::FACTOR_W;
	localparam int QW = bsc_pkg::QUOT_W;

	logic [2:0]                      state_q;
	logic [bsc_pkg::CNT_W-1:0]       cnt_q;
	logic [2:0]                      op_q;
	logic [2:0]                      ph_q;
	logic                            result_valid_q;
	logic [63:0]                     coef_word_low_q;
	logic [63:0]                     coef_word_high_q;
	logic [15:0]                     coef_cubic_q;
	logic [bsc_pkg::CODE_W-1:0]      temp_os_q;
	logic [bsc_pkg::CODE_W-1:0]      press_os_q;
	logic signed [QW:0]              last_scaled_temp_q;

	logic                            kind_q;
	logic                            err_q;
	bsc_pkg::factor_t                f_q;
	logic                            raw_neg_q;
	logic [FW-1:0]                   rem_q;
	logic [QW-1:0]                   nq_q;
	logic [31:0]                     mx_q;
	logic [63:0]                     my_q;
	logic                            neg_q;
	logic                            sh_q;
	logic signed [63:0]              addend_q;
	logic [63:0]                     pp_q;
	logic [95:0]                     acc_q;
	logic [63:0]                     rnd_q;
	logic signed [63:0]              run_q;
	logic signed [63:0]              a_q;
	logic signed [63:0]              sum_q;
	logic                            res_kind_q;
	logic signed [bsc_pkg::OUT_W-1:0] res_value_q;
	logic                            res_err_q;

	logic [bsc_pkg::CODE_W-1:0]      sel_code;
	bsc_pkg::factor_t                sel_factor;
	logic [bsc_pkg::RAW_W-1:0]       raw_mag;
	logic [47:0]                     num;
	logic [FW:0]                     div_trial;
	logic                            div_ge;
	logic [FW:0]                     div_rem;
	logic [QW-1:0]                   quot_next;
	logic signed [QW:0]              temp_next;
	logic [QW:0]                     t_mag;
	logic [31:0]                     x_mag;
	logic                            x_neg;
	logic signed [63:0]              y_sel;
	logic [63:0]                     y_mag;
	logic                            shift_sel;
	logic signed [63:0]              addend_sel;
	logic [95:0]                     rnd_full;
	logic signed [63:0]              mul_res;
	logic signed [63:0]              c00_sh;
	logic signed [63:0]              out_round;
	logic signed [bsc_pkg::OUT_W-1:0] out_sat;
	logic                            load_result;
	logic                            accept;

	assign accept      = sample_valid && sample_ready;
	assign load_result = (state_q == S_FIN) && (!result_valid_q || result_ready);

	assign sel_code   = command ? press_os_q : temp_os_q;
	assign sel_factor = bsc_pkg::scale_factor(sel_code[2:0]);
	assign raw_mag    = raw_sample[bsc_pkg::RAW_W-1] ? bsc_pkg::RAW_W'(-raw_sample) : raw_sample;
	assign num        = {raw_mag, 24'd0} + {26'd0, sel_factor[FW-1:1]};

	assign div_trial = {rem_q, nq_q[QW-1]};
	assign div_ge    = div_trial >= {1'b0, f_q};
	assign div_rem   = div_ge ? div_trial - {1'b0, f_q} : div_trial;
	assign quot_next = {nq_q[QW-2:0], div_ge};
	assign temp_next = raw_neg_q ? -$signed({1'b0, quot_next}) : $signed({1'b0, quot_next});

	assign t_mag = last_scaled_temp_q[QW] ? (QW+1)'(-last_scaled_temp_q)
		: last_scaled_temp_q;

	assign c00_sh = {{20{coef_word_low_q[39]}}, coef_word_low_q[39:20], 24'd0};

	always_comb begin
		if (op_q == OP_CROSS) begin
			x_mag = {1'b0, t_mag};
			x_neg = last_scaled_temp_q[QW];
		end else begin
			x_mag = {2'd0, nq_q};
			x_neg = raw_neg_q;
		end
		case (op_q)
			OP_CUBE: y_sel = {{48{coef_cubic_q[15]}}, coef_cubic_q};
			OP_C21:  y_sel = {{48{coef_word_high_q[15]}}, coef_word_high_q[15:0]};
			OP_TEMP: y_sel = {{52{coef_word_low_q[51]}}, coef_word_low_q[51:40]};
			default: y_sel = run_q;
		endcase
		y_mag     = y_sel[63] ? 64'(-y_sel) : y_sel;
		shift_sel = op_q inside {OP_QUAD, OP_LIN, OP_C11, OP_CROSS};
		case (op_q)
			OP_CUBE: addend_sel = {{24{coef_word_high_q[31]}}, coef_word_high_q[31:16], 24'd0};
			OP_QUAD: addend_sel = {{20{coef_word_low_q[19]}}, coef_word_low_q[19:0], 24'd0};
			OP_C21:  addend_sel = {{24{coef_word_high_q[47]}}, coef_word_high_q[47:32], 24'd0};
			OP_C11:  addend_sel = {{24{coef_word_high_q[63]}}, coef_word_high_q[63:48], 24'd0};
			OP_TEMP: addend_sel = {{29{coef_word_low_q[63]}}, coef_word_low_q[63:52], 23'd0};
			default: addend_sel = '0;
		endcase
	end

	assign rnd_full = acc_q + 96'd8388608;
	assign mul_res  = neg_q ? addend_q - $signed(rnd_q) : addend_q + $signed(rnd_q);

	always_comb begin
		out_round = (sum_q + (sum_q[63] ? 64'sd32767 : 64'sd32768)) >>> 16;
		if (out_round > 64'sd2147483647) begin
			out_sat = 32'sh7fffffff;
		end else if (out_round < -64'sd2147483648) begin
			out_sat = 32'sh80000000;
		end else begin
			out_sat = out_round[bsc_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= S_IDLE;
			cnt_q              <= '0;
			op_q               <= OP_CUBE;
			ph_q               <= PH_LOAD;
			result_valid_q     <= 1'b0;
			coef_word_low_q    <= '0;
			coef_word_high_q   <= '0;
			coef_cubic_q       <= '0;
			temp_os_q          <= '0;
			press_os_q         <= '0;
			last_scaled_temp_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bsc_pkg::REG_COEF_WORD_LOW:  coef_word_low_q  <= cfg_data;
					bsc_pkg::REG_COEF_WORD_HIGH: coef_word_high_q <= cfg_data;
					bsc_pkg::REG_COEF_CUBIC:     coef_cubic_q     <= cfg_data[15:0];
					bsc_pkg::REG_TEMP_OS:        temp_os_q        <= cfg_data[3:0];
					bsc_pkg::REG_PRESS_OS:       press_os_q       <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= sel_code[3] ? S_FIN : S_DIV;
						cnt_q   <= '0;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == bsc_pkg::CNT_W'(bsc_pkg::DIV_STEPS - 1)) begin
						state_q <= S_MUL;
						op_q    <= kind_q ? OP_CUBE : OP_TEMP;
						ph_q    <= PH_LOAD;
						if (!kind_q) begin
							last_scaled_temp_q <= temp_next;
						end
					end
				end
				S_MUL: begin
					if (ph_q == PH_ADD) begin
						ph_q <= PH_LOAD;
						if (op_q == OP_TEMP || op_q == OP_CROSS) begin
							state_q <= S_SUM;
						end else begin
							op_q <= op_q + 1'b1;
						end
					end else begin
						ph_q <= ph_q + 1'b1;
					end
				end
				S_SUM: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (load_result) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_q    <= command;
					err_q     <= sel_code[3];
					f_q       <= sel_factor;
					raw_neg_q <= raw_sample[bsc_pkg::RAW_W-1];
					rem_q     <= {5'd0, num[47:QW]};
					nq_q      <= num[QW-1:0];
					sum_q     <= '0;
				end
			end
			S_DIV: begin
				rem_q <= div_rem[FW-1:0];
				nq_q  <= quot_next;
			end
			S_MUL: begin
				case (ph_q)
					PH_LOAD: begin
						mx_q     <= x_mag;
						my_q     <= y_mag;
						neg_q    <= x_neg ^ y_sel[63];
						sh_q     <= shift_sel;
						addend_q <= addend_sel;
					end
					PH_LO: begin
						pp_q <= mx_q * my_q[31:0];
					end
					PH_HI: begin
						pp_q  <= mx_q * my_q[63:32];
						acc_q <= {32'd0, pp_q};
					end
					PH_ACC: begin
						acc_q <= acc_q + {pp_q, 32'd0};
					end
					PH_RND: begin
						rnd_q <= sh_q ? rnd_full[87:24] : acc_q[63:0];
					end
					PH_ADD: begin
						if (op_q == OP_LIN) begin
							a_q <= mul_res;
						end else begin
							run_q <= mul_res;
						end
					end
					default: ;
				endcase
			end
			S_SUM: begin
				sum_q <= kind_q ? c00_sh + a_q + run_q : run_q;
			end
			S_FIN: begin
				if (load_result) begin
					res_kind_q  <= kind_q;
					res_err_q   <= err_q;
					res_value_q <= err_q ? '0 : out_sat;
				end
			end
			default: ;
		endcase
	end

	assign sample_ready = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign result_kind  = res_kind_q;
	assign compensated  = res_value_q;
	assign error        = res_err_q;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && error) |-> (compensated == '0))
		else $error("error result carries a nonzero value");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("ready while a transaction is in work");

	a_temp_update: assert property (@(posedge clk) disable iff (!arst_n)
		(last_scaled_temp_q != $past(last_scaled_temp_q)) |->
		($past(state_q) == S_DIV && !$past(kind_q)))
		else $error("stored temperature changed outside a temperature transaction");

endmodule
